// File: rtl/fpcos_pkg.sv
// Shared constants and types of the first path-cutting obstacle search.
package fpcos_pkg;

   localparam int COORD_W     = 7;
   localparam int SIDE_W      = 9;
   localparam int INDEX_OUT_W = 12;
   localparam int ENTRY_W     = 2 * COORD_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [7:0] GRID_SIDE_RESET = 8'd71;

   // register index of grid_side on the configuration port
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_GRID_SIDE = '0;

   typedef enum logic [13:0] {
      S_LOAD     = 14'b00000000000001,
      S_CLEAR    = 14'b00000000000010,
      S_PLACE    = 14'b00000000000100,
      S_PLDRAIN  = 14'b00000000001000,
      S_PROBE    = 14'b00000000010000,
      S_START_EV = 14'b00000000100000,
      S_POP      = 14'b00000001000000,
      S_CELL     = 14'b00000010000000,
      S_NB_RD    = 14'b00000100000000,
      S_NB_EV    = 14'b00001000000000,
      S_DECIDE   = 14'b00010000000000,
      S_NEXT     = 14'b00100000000000,
      S_PICK     = 14'b01000000000000,
      S_OUT      = 14'b10000000000000
   } state_type;

endpackage

// File: rtl/fpcos_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module fpcos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/first_path_cutting_obstacle_search.sv
// Top level of the first path-cutting obstacle search: loader, flood engine and search.
//
// Use: obstacle cells stream in on req_ (tdata = column, row; tlast marks the final
// obstacle of a sequence). Each item is one write into the obstacle store, so loading
// takes one cycle per item. Once MAX_OBSTACLES are held further items are dropped, but a
// dropped item with tlast still starts the search.
// On the final item the block stops taking items and:
//   - clears the blocked and visited maps, one cell per cycle,
//   - marks the cell of each obstacle inside the grid with the lowest index placed on it,
//   - runs a breadth-first flood per binary-search probe, popping each reached cell from
//     the queue and checking its neighbours one at a time through the shared map read port,
//   - probes at most log2(MAX_OBSTACLES)+1 times, then reads the chosen obstacle.
// The one result item leaves on rsp_: tuser = path_cut, tdata = column, row, index.
// The result is held in an output register; loading of the next sequence resumes at once,
// and a further search waits at its end only while an earlier result is still untaken.
// The user must write grid_side on the csr_ port only while the block is idle (unchecked).
// Reset (synchronous, active high) empties the sequence, drops any pending result and
// sets grid_side to 71; map contents need no reset as each search clears them first.
module first_path_cutting_obstacle_search
   import fpcos_pkg::*;
#(
   parameter int GRID_MAX      = 128,
   parameter int MAX_OBSTACLES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [6:0] obstacle_col, [13:7] obstacle_row
   input  logic                  req_tlast,   // last_obstacle
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [6:0] cut_col, [13:7] cut_row, [25:14] cut_index
   output logic                  rsp_tuser,   // path_cut
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CW    = $clog2(GRID_MAX);
   localparam int AW    = 2 * CW;
   localparam int CELLS = 1 << AW;
   localparam int IW    = $clog2(MAX_OBSTACLES);
   localparam int NW    = $clog2(MAX_OBSTACLES + 1);
   localparam int EW    = $clog2(NW + 3);
   localparam int BW    = IW + 1;

   // ---------------------------------------------------------------- configuration
   logic [7:0] grid_side_ff, grid_side_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_GRID_SIDE);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_GRID_SIDE) ?
                       {24'd0, grid_side_ff} : '0;

   always_comb begin
      grid_side_in = grid_side_ff;
      if (csr_wr) begin
         grid_side_in = csr_pwdata[7:0];
      end
   end

   // ---------------------------------------------------------------- registers
   state_type         state_ff, state_in;
   logic [NW-1:0]     count_ff, count_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [NW-1:0]     lo1_ff, lo1_in;    // search low plus one
   logic [IW-1:0]     hi_ff, hi_in;
   logic [IW-1:0]     mid_ff, mid_in;
   logic              first_ff, first_in;
   logic              reach_ff, reach_in;
   logic              cut_ff, cut_in;
   logic [EW-1:0]     epoch_ff, epoch_in;
   logic [AW:0]       sweep_ff, sweep_in;
   logic [IW-1:0]     place_ff, place_in;
   logic              pv_ff, pv_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   logic [AW:0]       head_ff, head_in;
   logic [AW:0]       tail_ff, tail_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     nb_ff, nb_in;
   logic [1:0]        dir_ff, dir_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   // ---------------------------------------------------------------- memories
   logic              obs_we, obs_re;
   logic [IW-1:0]     obs_waddr, obs_raddr;
   logic [ENTRY_W-1:0] obs_wdata, obs_rdata;

   logic              blk_we, map_re;
   logic [AW-1:0]     blk_waddr, map_raddr;
   logic [BW-1:0]     blk_wdata, blk_rdata;

   logic              vis_we;
   logic [AW-1:0]     vis_waddr;
   logic [EW-1:0]     vis_wdata, vis_rdata;

   logic              q_we, q_re;
   logic [AW-1:0]     q_waddr, q_raddr, q_rdata;
   logic [AW-1:0]     q_wdata_w;

   fpcos_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << IW)) u_obs_ram (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr), .wr_data(obs_wdata),
      .rd_en(obs_re), .rd_addr(obs_raddr), .rd_data(obs_rdata)
   );

   // each cell holds {valid, lowest obstacle index placed on it}
   fpcos_ram #(.WIDTH(BW), .DEPTH(CELLS)) u_blk_ram (
      .clock(clock), .wr_en(blk_we), .wr_addr(blk_waddr), .wr_data(blk_wdata),
      .rd_en(map_re), .rd_addr(map_raddr), .rd_data(blk_rdata)
   );

   // each cell holds the number of the probe that last visited it
   fpcos_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_vis_ram (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_en(map_re), .rd_addr(map_raddr), .rd_data(vis_rdata)
   );

   fpcos_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata_w),
      .rd_en(q_re), .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   // ---------------------------------------------------------------- helpers
   logic              req_acc;
   logic [SIDE_W-1:0] gs9, side_clamped;
   logic [NW-1:0]     count_stored;
   logic [SIDE_W-1:0] pl_col9, pl_row9;
   logic [SIDE_W-1:0] cur_col9, cur_row9, side_m1;
   logic [CW-1:0]     cur_col, cur_row;
   logic [AW-1:0]     goal;
   logic              blocked, fresh;
   logic              nb_ok;
   logic [AW-1:0]     nb_addr;
   logic [NW-1:0]     low_w, mid_w;
   logic              out_free;
   logic [IW+INDEX_OUT_W-1:0] idx_wide;

   assign req_acc = req_tvalid && req_tready;
   assign gs9 = {1'b0, grid_side_ff};
   always_comb begin
      if (gs9 == '0) begin
         side_clamped = SIDE_W'(1);
      end else if (gs9 > SIDE_W'(GRID_MAX)) begin
         side_clamped = SIDE_W'(GRID_MAX);
      end else begin
         side_clamped = gs9;
      end
   end

   assign count_stored = (count_ff < NW'(MAX_OBSTACLES)) ? count_ff + NW'(1) : count_ff;

   assign pl_col9 = SIDE_W'(obs_rdata[COORD_W-1:0]);
   assign pl_row9 = SIDE_W'(obs_rdata[ENTRY_W-1:COORD_W]);

   assign cur_col  = cur_ff[CW-1:0];
   assign cur_row  = cur_ff[AW-1:CW];
   assign cur_col9 = SIDE_W'(cur_col);
   assign cur_row9 = SIDE_W'(cur_row);
   assign side_m1  = side_ff - SIDE_W'(1);
   assign goal     = {side_m1[CW-1:0], side_m1[CW-1:0]};

   // a cell is blocked in this probe if an obstacle of the probed prefix sits there
   assign blocked = blk_rdata[BW-1] && (blk_rdata[IW-1:0] <= mid_ff);
   assign fresh   = !blocked && (vis_rdata != epoch_ff);

   // neighbour order: right, left, down, up
   always_comb begin
      nb_ok   = 1'b0;
      nb_addr = cur_ff;
      case (dir_ff)
         2'd0: begin
            nb_ok   = (cur_col9 + SIDE_W'(1)) < side_ff;
            nb_addr = {cur_row, cur_col + CW'(1)};
         end
         2'd1: begin
            nb_ok   = cur_col != '0;
            nb_addr = {cur_row, cur_col - CW'(1)};
         end
         2'd2: begin
            nb_ok   = (cur_row9 + SIDE_W'(1)) < side_ff;
            nb_addr = {cur_row + CW'(1), cur_col};
         end
         default: begin
            nb_ok   = cur_row != '0;
            nb_addr = {cur_row - CW'(1), cur_col};
         end
      endcase
   end

   // mid = low + (high - low) / 2 with low = lo1 - 1
   assign low_w = lo1_ff - NW'(1);
   assign mid_w = low_w + ((NW'(hi_ff) - low_w) >> 1);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idx_wide = (IW + INDEX_OUT_W)'(hi_ff);

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      side_in      = side_ff;
      lo1_in       = lo1_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      first_in     = first_ff;
      reach_in     = reach_ff;
      cut_in       = cut_ff;
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      place_in     = place_ff;
      pv_in        = 1'b0;
      pidx_in      = place_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      nb_in        = nb_ff;
      dir_in       = dir_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      obs_we    = 1'b0;
      obs_waddr = count_ff[IW-1:0];
      obs_wdata = req_tdata[ENTRY_W-1:0];
      obs_re    = 1'b0;
      obs_raddr = place_ff;

      // place an obstacle read out in the previous cycle
      blk_we    = pv_ff && (pl_col9 < side_ff) && (pl_row9 < side_ff);
      blk_waddr = {pl_row9[CW-1:0], pl_col9[CW-1:0]};
      blk_wdata = {1'b1, pidx_ff};

      vis_we    = 1'b0;
      vis_waddr = nb_ff;
      vis_wdata = epoch_ff;
      map_re    = 1'b0;
      map_raddr = nb_addr;

      q_we      = 1'b0;
      q_waddr   = tail_ff[AW-1:0];
      q_wdata_w = nb_ff;
      q_re      = 1'b0;
      q_raddr   = head_ff[AW-1:0];

      req_tready = 1'b0;

      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_acc) begin
               obs_we   = count_ff < NW'(MAX_OBSTACLES);
               count_in = count_stored;
               if (req_tlast) begin
                  side_in  = side_clamped;
                  lo1_in   = '0;
                  hi_in    = IW'(count_stored - NW'(1));
                  sweep_in = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            blk_we    = 1'b1;
            blk_waddr = sweep_ff[AW-1:0];
            blk_wdata = '0;
            vis_we    = 1'b1;
            vis_waddr = sweep_ff[AW-1:0];
            vis_wdata = '0;
            sweep_in  = sweep_ff + (AW+1)'(1);
            if (sweep_ff == (AW+1)'(CELLS - 1)) begin
               place_in = hi_ff;
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            // walk the list downwards so the lowest index is written last
            obs_re = 1'b1;
            pv_in  = 1'b1;
            if (place_ff == '0) begin
               state_in = S_PLDRAIN;
            end else begin
               place_in = place_ff - IW'(1);
            end
         end
         S_PLDRAIN: begin
            mid_in   = hi_ff;
            first_in = 1'b1;
            epoch_in = '0;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            epoch_in  = epoch_ff + EW'(1);
            map_re    = 1'b1;
            map_raddr = '0;
            head_in   = '0;
            tail_in   = '0;
            state_in  = S_START_EV;
         end
         S_START_EV: begin
            if (blocked) begin
               reach_in = 1'b0;
               state_in = S_DECIDE;
            end else begin
               vis_we    = 1'b1;
               vis_waddr = '0;
               q_we      = 1'b1;
               q_waddr   = '0;
               q_wdata_w = '0;
               tail_in   = (AW+1)'(1);
               state_in  = S_POP;
            end
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               reach_in = 1'b0;
               state_in = S_DECIDE;
            end else begin
               q_re     = 1'b1;
               head_in  = head_ff + (AW+1)'(1);
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            if (q_rdata == goal) begin
               reach_in = 1'b1;
               state_in = S_DECIDE;
            end else begin
               cur_in   = q_rdata;
               dir_in   = '0;
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            if (nb_ok) begin
               map_re   = 1'b1;
               nb_in    = nb_addr;
               state_in = S_NB_EV;
            end else begin
               dir_in = dir_ff + 2'd1;
               if (dir_ff == 2'd3) begin
                  state_in = S_POP;
               end
            end
         end
         S_NB_EV: begin
            if (fresh) begin
               vis_we  = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + (AW+1)'(1);
            end
            dir_in = dir_ff + 2'd1;
            if (dir_ff == 2'd3) begin
               state_in = S_POP;
            end else begin
               state_in = S_NB_RD;
            end
         end
         S_DECIDE: begin
            if (first_ff) begin
               first_in = 1'b0;
               cut_in   = !reach_ff;
               if (reach_ff) begin
                  state_in = S_PICK;
               end else begin
                  state_in = S_NEXT;
               end
            end else begin
               if (reach_ff) begin
                  lo1_in = NW'(mid_ff) + NW'(1);
               end else begin
                  hi_in = mid_ff;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (lo1_ff < NW'(hi_ff)) begin
               mid_in   = mid_w[IW-1:0];
               state_in = S_PROBE;
            end else begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            obs_re    = 1'b1;
            obs_raddr = hi_ff;
            state_in  = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = cut_ff;
               rsp_data_in  = {6'd0, idx_wide[INDEX_OUT_W-1:0], obs_rdata};
               count_in     = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         grid_side_ff <= GRID_SIDE_RESET;
         pv_ff        <= 1'b0;
         first_ff     <= 1'b0;
         epoch_ff     <= '0;
         lo1_ff       <= '0;
         hi_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         grid_side_ff <= grid_side_in;
         pv_ff        <= pv_in;
         first_ff     <= first_in;
         epoch_ff     <= epoch_in;
         lo1_ff       <= lo1_in;
         hi_ff        <= hi_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
      side_ff     <= side_in;
      mid_ff      <= mid_in;
      reach_ff    <= reach_in;
      cut_ff      <= cut_in;
      sweep_ff    <= sweep_in;
      place_ff    <= place_in;
      pidx_ff     <= pidx_in;
      cur_ff      <= cur_in;
      nb_ff       <= nb_in;
      dir_ff      <= dir_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_OBSTACLES))
      else $error("obstacle count beyond capacity");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (tail_ff <= (AW+1)'(CELLS)))
      else $error("flood queue pointers out of order");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && !first_ff) |-> (lo1_ff <= NW'(mid_ff)) && (mid_ff < hi_ff))
      else $error("probe outside the search interval");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule
